// File: design/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg: shared types for the insertion sorter
// Beat payloads for the input and result channels and the per-cycle control
// word that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int unsigned DataWidth = 32;

    // One input beat: an element of the set and its end marker.
    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic                        is_final;
    } in_beat_t;

    // One result beat: the next element in ascending order.
    typedef struct packed {
        logic signed [DataWidth-1:0] sorted_value;
        logic                        end_of_set;
        logic                        dropped;
    } out_beat_t;

    // Command broadcast to all cells in a cycle.
    typedef struct packed {
        logic insert;   // place the incoming value into the chain
        logic shift;    // move every entry one cell toward the output
    } cell_ctrl_t;

endpackage

// File: design/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell: one compare-and-shift cell of the sorting chain
// Holds one element. On insert it keeps its value, takes the new value, or
// takes its left neighbor's value; on shift it takes its right neighbor's.
// ----------------------------------------------------------------------------
module isort_cell
    import isort_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cell_ctrl_t                  ctrl,
    input  logic signed [DataWidth-1:0] new_value,
    // Left neighbor (toward the output end).
    input  logic signed [DataWidth-1:0] left_data,
    input  logic                        left_valid,
    input  logic                        left_open,
    // Right neighbor (toward the tail).
    input  logic signed [DataWidth-1:0] right_data,
    input  logic                        right_valid,
    // This cell's state.
    output logic signed [DataWidth-1:0] data,
    output logic                        valid,
    output logic                        open
);

    logic signed [DataWidth-1:0] data_reg, data_next;
    logic                        valid_reg, valid_next;

    // A cell is open when the new value belongs at or before it: it is
    // empty or holds a strictly greater value. Open cells form a suffix.
    assign open = !valid_reg || (data_reg > new_value);

    // Next contents of the cell.
    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.insert) begin
            if (left_open) begin
                // Make room: the left neighbor's entry moves in. An empty
                // left neighbor leaves this cell empty as well.
                data_next  = left_data;
                valid_next = left_valid;
            end else if (open) begin
                // First open cell receives the new value.
                data_next  = new_value;
                valid_next = 1'b1;
            end
        end else if (ctrl.shift) begin
            data_next  = right_data;
            valid_next = right_valid;
        end
    end

    // Valid bit is control state; the data register needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// File: design/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter: streaming insertion sorter on a chain of cells
// Collects signed 32-bit elements and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one element per beat; is_final marks the last one
//   of a set. Each element is inserted into a row of DEPTH compare-and-shift
//   cells in the cycle it is accepted, so a set loads at one beat per cycle.
//   Equal elements keep their arrival order. Elements beyond DEPTH are
//   discarded and every result of that set carries dropped.
//   After the final beat, s_ready falls and the set leaves on the m_ channel
//   from the head cell, one beat per cycle while m_ready is high; the chain
//   shifts one cell toward the head per result. The first result appears
//   the cycle after the final beat; the last result of the set carries
//   end_of_set. If the receiver stalls, the head result and the chain
//   simply hold. s_ready returns the cycle after the last result.
//   A synchronous reset (aresetn low) empties every cell and clears the
//   drop flag.
// ----------------------------------------------------------------------------
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic signed [DataWidth-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]            cell_valid;
    logic [DEPTH-1:0]            cell_open;
    cell_ctrl_t                  ctrl;

    logic draining_reg, draining_next;
    logic overflow_reg, overflow_next;
    logic s_fire, m_fire, full, last_out;

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign full     = cell_valid[DEPTH-1];
    assign last_out = !cell_valid[1];

    // Broadcast command: insert while loading, shift while draining.
    assign ctrl.insert = s_fire && !full;
    assign ctrl.shift  = m_fire;

    // Load/drain control.
    always_comb begin
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        if (s_fire) begin
            if (full) begin
                overflow_next = 1'b1;
            end
            if (s_data.is_final) begin
                draining_next = 1'b1;
            end
        end else if (m_fire && last_out) begin
            draining_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end else begin
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

    // The chain of cells; cell 0 is the head and feeds the result channel.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DataWidth-1:0] left_data;
        logic                        left_valid;
        logic                        left_open;
        logic signed [DataWidth-1:0] right_data;
        logic                        right_valid;

        if (i == 0) begin : g_head
            assign left_data  = '0;
            assign left_valid = 1'b0;
            assign left_open  = 1'b0;
        end else begin : g_body
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_open  = cell_open[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        isort_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_value   (s_data.value),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .left_open   (left_open),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .open        (cell_open[i])
        );
    end

    // Channel outputs come straight from registers.
    assign s_ready             = !draining_reg;
    assign m_valid             = draining_reg;
    assign m_data.sorted_value = cell_data[0];
    assign m_data.end_of_set   = last_out;
    assign m_data.dropped      = overflow_reg;

    // A result is only offered from an occupied head cell.
    a_head_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cell_valid[0])
        else $error("result offered from an empty head cell");

    // Occupied cells always form a contiguous run starting at the head.
    a_prefix : assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("gap in the occupied cells of the chain");

    // Loading and draining never overlap.
    a_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while results are pending");

    // A final beat starts the drain in the next cycle.
    a_final_drains : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.is_final) |=> m_valid)
        else $error("final beat did not start the drain");

endmodule

// File: sim/insertion_sorter_test.sv
// ----------------------------------------------------------------------------
// insertion_sorter_test: self-checking bench for the streaming insertion sorter
// Sets of signed elements go in on the s_ channel. A behavioral sort of each
// set predicts the result beats, and these are matched in order against the
// m_ channel. Extreme values, duplicates, single-element sets, a full store
// and overflowing sets are covered. The sender runs in bursts and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module insertion_sorter_test;
    import isort_pkg::*;

    localparam int unsigned SetCapacity   = 64;
    localparam int unsigned ItemTarget    = 430;
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned ReportLimit   = 10;

    localparam logic signed [DataWidth-1:0] MaxValue = 32'sh7FFF_FFFF;
    localparam logic signed [DataWidth-1:0] MinValue = 32'sh8000_0000;

    // Receiver behaviors, each held for a random stretch of cycles.
    typedef enum logic [1:0] {
        RecvSteady,
        RecvCoinFlip,
        RecvEveryThird,
        RecvLongStall
    } recv_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Beats waiting to be sent, and results expected back in order.
    in_beat_t  pending_beats[$];
    out_beat_t sorted_expect[$];

    // Behavioral copy of the sorting chain.
    logic signed [DataWidth-1:0] chain_entries[SetCapacity];
    int unsigned chain_count = 0;
    bit          chain_dropped = 1'b0;

    int unsigned total_items = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned recv_hold = 0;
    int unsigned recv_phase = 0;
    recv_mode_t  recv_mode = RecvSteady;

    insertion_sorter #(
        .DEPTH (SetCapacity)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Insert one accepted element; on the final one, emit the whole set.
    task automatic absorb_element(input in_beat_t beat);
        int unsigned pos;
        out_beat_t   result;
        if (chain_count < SetCapacity) begin
            pos = chain_count;
            while (pos > 0 && $signed(chain_entries[pos-1]) > $signed(beat.value)) begin
                chain_entries[pos] = chain_entries[pos-1];
                pos--;
            end
            chain_entries[pos] = beat.value;
            chain_count++;
        end else begin
            chain_dropped = 1'b1;
        end
        if (beat.is_final) begin
            for (int unsigned k = 0; k < chain_count; k++) begin
                result.sorted_value = chain_entries[k];
                result.end_of_set   = (k + 1 == chain_count);
                result.dropped      = chain_dropped;
                sorted_expect.push_back(result);
            end
            chain_count   = 0;
            chain_dropped = 1'b0;
        end
    endtask

    function automatic logic signed [DataWidth-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: pick_value = MaxValue - $urandom_range(0, 2);
            1: pick_value = MinValue + $urandom_range(0, 2);
            2, 3: pick_value = $signed($urandom_range(0, 8)) - 4;
            default: pick_value = $urandom;
        endcase
    endfunction

    task automatic queue_element(input logic signed [DataWidth-1:0] value, input bit last);
        in_beat_t beat;
        beat.value    = value;
        beat.is_final = last;
        pending_beats.push_back(beat);
    endtask

    task automatic queue_random_set(input int unsigned size);
        for (int unsigned k = 0; k < size; k++) begin
            queue_element(pick_value(), k + 1 == size);
        end
    endtask

    // Stimulus, reset sequence and end of run.
    initial begin
        int unsigned set_index;
        int unsigned set_size;

        // Single-element sets at both extremes.
        queue_element(MaxValue, 1'b1);
        queue_element(MinValue, 1'b1);
        // Mixed signs with both extremes in the middle of a set.
        queue_element(0, 1'b0);
        queue_element(-1, 1'b0);
        queue_element(1, 1'b0);
        queue_element(MinValue, 1'b0);
        queue_element(MaxValue, 1'b0);
        queue_element(7, 1'b0);
        queue_element(-7, 1'b1);
        // Duplicates.
        queue_element(3, 1'b0);
        queue_element(3, 1'b0);
        queue_element(-2, 1'b0);
        queue_element(3, 1'b0);
        queue_element(-2, 1'b1);
        // Already ascending, then strictly descending.
        for (int k = 1; k <= 4; k++) begin
            queue_element(10 * k, k == 4);
        end
        for (int k = 4; k >= 1; k--) begin
            queue_element(10 * k, k == 1);
        end

        // Random sets, mostly small; a full store and two overflows among them.
        set_index = 0;
        while (pending_beats.size() < ItemTarget) begin
            case (set_index)
                5:  set_size = SetCapacity;
                15: set_size = SetCapacity + 1;
                25: set_size = $urandom_range(SetCapacity + 2, SetCapacity + 11);
                default: set_size = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                                : $urandom_range(1, 6);
            endcase
            queue_random_set(set_size);
            set_index++;
        end
        total_items = pending_beats.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < total_items || sorted_expect.size() != 0) begin
            @(posedge aclk);
        end
        // Let the clock run on to catch any stray result beats.
        repeat (SetCapacity / 4) @(posedge aclk);

        if (mismatch_count == 0 && sorted_expect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Sender: bursts of beats with random gaps in between.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || pending_beats.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
            end else begin
                s_valid <= 1'b1;
                s_data  <= pending_beats.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: switch among stall patterns every so often.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            recv_phase <= recv_phase + 1;
            if (recv_hold == 0) begin
                recv_mode <= recv_mode_t'($urandom_range(0, 3));
                recv_hold <= $urandom_range(8, 80);
            end else begin
                recv_hold <= recv_hold - 1;
            end
            case (recv_mode)
                RecvSteady:     m_ready <= 1'b1;
                RecvCoinFlip:   m_ready <= $urandom_range(0, 1);
                RecvEveryThird: m_ready <= (recv_phase % 3 != 0);
                default:        m_ready <= (recv_phase % 12 == 0);
            endcase
        end
    end

    // Monitor: predict on input beats, check result beats in order.
    always @(posedge aclk) begin
        out_beat_t wanted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                absorb_element(s_data);
                items_accepted <= items_accepted + 1;
            end
            if (m_valid && m_ready) begin
                if (sorted_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit) begin
                        $display("Unexpected result beat: value %0d end %0b dropped %0b",
                                 m_data.sorted_value, m_data.end_of_set, m_data.dropped);
                    end
                end else begin
                    wanted = sorted_expect.pop_front();
                    if (m_data.sorted_value !== wanted.sorted_value ||
                        m_data.end_of_set !== wanted.end_of_set ||
                        m_data.dropped !== wanted.dropped) begin
                        mismatch_count++;
                        if (mismatch_count <= ReportLimit) begin
                            $display({"Result mismatch: expected value %0d end %0b ",
                                      "dropped %0b, got value %0d end %0b dropped %0b"},
                                     wanted.sorted_value, wanted.end_of_set,
                                     wanted.dropped, m_data.sorted_value,
                                     m_data.end_of_set, m_data.dropped);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WatchdogLimit) begin
                $display("Timeout: no beat moved for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
